// ----- rtl/cgl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgl_pkg
// Shared types and constants of the cylinder grid local maximum block.
// ----------------------------------------------------------------------------
package cgl_pkg;

    localparam int MAX_ROWS_DEF    = 256;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int COL_W     = 12;  // column index / column_count width
    localparam int OUT_ROW_W = 8;   // reported row width
    localparam int RPC_W     = 9;   // rows_per_column register width
    localparam int CFG_W     = 12;  // config data width

    localparam logic [COL_W-1:0] MAX_COLS = 12'd4095;

    // result queue
    localparam int MAX_RES = 4;
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                 is_peak;
        logic [COL_W-1:0]     column;
        logic [OUT_ROW_W-1:0] row;
        logic                 last;
    } res_t;

endpackage

// ----- rtl/cylinder_grid_local_maximum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_grid_local_maximum
// 3x3 strict local maximum over a grid that wraps in azimuth, streamed
// column by column; results carry column and row.
// ----------------------------------------------------------------------------
//  channel  | dir | signals
//  ---------+-----+--------------------------------------------------
//  s_       | in  | s_valid s_ready s_sample s_grid_start
//  m_       | out | m_valid m_ready m_is_peak m_out_column m_out_row m_last
//  cfg_     | in  | cfg_valid cfg_ready cfg_index cfg_data
//
//  One sample beat per cycle. Each beat pushes 0..4 results into an 8-entry
//  queue that drains one result per cycle while m_ready is high; s_ready
//  drops while fewer than four slots are free. After rows_per_column is
//  lowered below the current row, ST_FILL_A and ST_FILL_B first reload
//  the row window from the column store. Reset clears position and queue,
//  not the store. m_ready stalls only back up through the queue.
// ----------------------------------------------------------------------------
module cylinder_grid_local_maximum #(
    parameter int MAX_ROWS    = cgl_pkg::MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = cgl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_sample,
    input  logic                           s_grid_start,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_is_peak,
    output logic [cgl_pkg::COL_W-1:0]      m_out_column,
    output logic [cgl_pkg::OUT_ROW_W-1:0]  m_out_row,
    output logic                           m_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  cgl_pkg::cfg_idx_t              cfg_index,
    input  logic [cgl_pkg::CFG_W-1:0]      cfg_data
);
    import cgl_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef enum logic [1:0] { ST_RUN, ST_FILL_A, ST_FILL_B } st_t;

    // ---------------- configuration
    logic [RPC_W-1:0] rows_cfg_reg;
    logic [COL_W-1:0] cols_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= RPC_W'(64);
            cols_cfg_reg <= COL_W'(64);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROWS: rows_cfg_reg <= cfg_data[RPC_W-1:0];
                CFG_COLS: cols_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [ROWS_W-1:0] rows_eff;
    logic [ROW_W-1:0]  last_row;
    logic [COL_W-1:0]  cols_eff;
    logic [COL_W-1:0]  last_col;

    always_comb begin
        if (rows_cfg_reg < RPC_W'(3))
            rows_eff = ROWS_W'(3);
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS))
            rows_eff = ROWS_W'(MAX_ROWS);
        else
            rows_eff = ROWS_W'(rows_cfg_reg);
        last_row = ROW_W'(rows_eff - ROWS_W'(1));
        if (cols_cfg_reg < COL_W'(3))
            cols_eff = COL_W'(3);
        else
            cols_eff = cols_cfg_reg;
        last_col = cols_eff - COL_W'(1);
    end

    // ---------------- position and window state
    st_t              state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [1:0]       slot_reg, slot_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] win_row_reg, win_row_next;

    smp_t win2_reg [3];
    smp_t win1_reg [3];
    smp_t z0_reg   [3];
    smp_t z1_reg   [3];
    smp_t pf_reg   [3];
    smp_t col_store_reg [MAX_ROWS][3];

    // result queue
    res_t             q_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]  cnt_reg;

    // window row needed for the current state position
    logic [ROW_W-1:0] e_state;
    logic             need_fill;

    assign e_state   = (row_reg >= last_row) ? last_row : row_reg;
    assign need_fill = (row_reg >= ROW_W'(2)) && (win_row_reg != e_state);

    assign s_ready = (state_reg == ST_RUN) && !need_fill
                   && (cnt_reg <= Q_CW'(Q_DEPTH - MAX_RES));

    logic acc;
    assign acc = s_valid && s_ready;

    // ---------------- item decode
    logic [COL_W-1:0] k, p;
    logic [ROW_W-1:0] r, e;
    logic [1:0]       sk, sp, sq;
    logic             col_end;

    always_comb begin
        k  = s_grid_start ? '0 : col_reg;
        r  = s_grid_start ? '0 : row_reg;
        sk = s_grid_start ? 2'd0 : slot_reg;
        p  = k - COL_W'(1);
        unique case (sk)
            2'd0:    begin sp = 2'd2; sq = 2'd1; end
            2'd1:    begin sp = 2'd0; sq = 2'd2; end
            default: begin sp = 2'd1; sq = 2'd0; end
        endcase
        col_end = (r >= last_row);
        e       = col_end ? last_row : r;
    end

    // row e of all three slots: the beat itself supplies its own slot
    smp_t prow [3];
    always_comb begin
        for (int s = 0; s < 3; s++) begin
            prow[s] = ((2'(s) == sk) && (e == r)) ? s_sample : pf_reg[s];
        end
    end

    function automatic logic beats8(input smp_t c, input smp_t n0, input smp_t n1,
                                    input smp_t n2, input smp_t n3, input smp_t n4,
                                    input smp_t n5, input smp_t n6, input smp_t n7);
        beats8 = (c > n0) && (c > n1) && (c > n2) && (c > n3)
              && (c > n4) && (c > n5) && (c > n6) && (c > n7);
    endfunction

    logic p_inner, pk_a, pk_b, pk_c;
    always_comb begin
        p_inner = (p != '0) && (p < last_col);
        // row e-1
        pk_a = p_inner && beats8(win1_reg[sp],
                   win2_reg[sq], win2_reg[sp], win2_reg[sk],
                   win1_reg[sq], win1_reg[sk],
                   prow[sq], prow[sp], prow[sk]);
        // row e
        pk_b = p_inner && beats8(prow[sp],
                   win1_reg[sq], win1_reg[sp], win1_reg[sk],
                   prow[sq], prow[sk],
                   z0_reg[sq], z0_reg[sp], z0_reg[sk]);
        // deferred row 0
        pk_c = p_inner && beats8(z0_reg[sp],
                   prow[sq], prow[sp], prow[sk],
                   z0_reg[sq], z0_reg[sk],
                   z1_reg[sq], z1_reg[sp], z1_reg[sk]);
    end

    // pack the candidate results in order
    res_t             cand [MAX_RES];
    logic [MAX_RES-1:0] cand_en;
    res_t             ent  [MAX_RES];
    logic [2:0]       n_res;

    always_comb begin
        cand[0] = '{is_peak: pk_a, column: p, row: OUT_ROW_W'(e - ROW_W'(1)), last: 1'b0};
        cand[1] = '{is_peak: pk_b, column: p, row: OUT_ROW_W'(e), last: 1'b0};
        cand[2] = '{is_peak: pk_c, column: p, row: '0, last: 1'b0};
        cand[3] = '{is_peak: 1'b0, column: k, row: OUT_ROW_W'(r), last: 1'b0};
        cand_en[0] = (k != '0) && (col_end || (r >= ROW_W'(2)));
        cand_en[1] = (k != '0) && col_end;
        cand_en[2] = (k != '0) && col_end;
        cand_en[3] = (k >= last_col);
        n_res = '0;
        for (int i = 0; i < MAX_RES; i++) ent[i] = cand[i];
        for (int i = 0; i < MAX_RES; i++) begin
            if (cand_en[i]) begin
                ent[n_res[1:0]] = cand[i];
                n_res = n_res + 3'd1;
            end
        end
        for (int i = 0; i < MAX_RES; i++) begin
            ent[i].last = (3'(i) == n_res - 3'd1);
        end
    end

    // ---------------- next position / fill sequencer
    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        slot_next    = slot_reg;
        row_next     = row_reg;
        win_row_next = win_row_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (acc) begin
                    if (col_end) begin
                        row_next = '0;
                        if (k >= last_col) begin
                            col_next  = '0;
                            slot_next = 2'd0;
                        end else begin
                            col_next  = k + COL_W'(1);
                            slot_next = (sk == 2'd2) ? 2'd0 : sk + 2'd1;
                        end
                    end else begin
                        row_next = r + ROW_W'(1);
                        col_next = k;
                        slot_next = sk;
                    end
                    win_row_next = row_next;
                end else if (need_fill) begin
                    win_row_next = e_state - ROW_W'(2);
                    state_next   = ST_FILL_A;
                end
            end
            ST_FILL_A: begin
                win_row_next = e_state - ROW_W'(1);
                state_next   = ST_FILL_B;
            end
            ST_FILL_B: begin
                win_row_next = e_state;
                state_next   = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            col_reg     <= '0;
            slot_reg    <= 2'd0;
            row_reg     <= '0;
            win_row_reg <= '0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            slot_reg    <= slot_next;
            row_reg     <= row_next;
            win_row_reg <= win_row_next;
        end
    end

    // column store: one row of three slots per address, lane write enable
    always_ff @(posedge aclk) begin
        if (acc) col_store_reg[r][sk] <= s_sample;
        for (int s = 0; s < 3; s++) pf_reg[s] <= col_store_reg[win_row_next][s];
    end

    // row window and rows 0/1 of each slot
    always_ff @(posedge aclk) begin
        if (acc) begin
            for (int s = 0; s < 3; s++) begin
                win2_reg[s] <= win1_reg[s];
                win1_reg[s] <= (2'(s) == sk) ? s_sample : pf_reg[s];
            end
            if (r == ROW_W'(0)) z0_reg[sk] <= s_sample;
            if (r == ROW_W'(1)) z1_reg[sk] <= s_sample;
        end else if (state_reg == ST_FILL_A) begin
            for (int s = 0; s < 3; s++) win2_reg[s] <= pf_reg[s];
        end else if (state_reg == ST_FILL_B) begin
            for (int s = 0; s < 3; s++) win1_reg[s] <= pf_reg[s];
        end
    end

    // ---------------- result queue
    logic            pop;
    logic [2:0]      n_push;

    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;
    assign n_push  = acc ? n_res : 3'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_AW'(n_push);
            rd_ptr_reg <= rd_ptr_reg + Q_AW'(pop);
            cnt_reg    <= cnt_reg + Q_CW'(n_push) - Q_CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (3'(i) < n_push) q_reg[Q_AW'(wr_ptr_reg + Q_AW'(i))] <= ent[i];
        end
    end

    res_t q_head;
    assign q_head       = q_reg[rd_ptr_reg];
    assign m_is_peak    = q_head.is_peak;
    assign m_out_column = q_head.column;
    assign m_out_row    = q_head.row;
    assign m_last       = q_head.last;

endmodule
